// File: rtl/core/uid_password_derivation_defines.svh
// ----------------------------------------------------------------------------
// uid_password_derivation_defines: assertion macros
// Concurrent assertion wrappers for the password derivation block; an
// ASSERT_OFF build turns them into empty text.
// ----------------------------------------------------------------------------
`ifndef UID_PASSWORD_DERIVATION_DEFINES_SVH
`define UID_PASSWORD_DERIVATION_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, ignored while reset is high.
`define UPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("uid_password_derivation: check failed");
// Clocked check that also covers the reset cycles.
`define UPD_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("uid_password_derivation: reset check failed");
`else
`define UPD_ASSERT(label, clk, rst, prop)
`define UPD_ASSERT_NORST(label, clk, prop)
`endif

`endif

// File: rtl/core/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: password derivation package
// Field widths, SHA-1 constants and small index helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int UID_BYTES  = 7;
   localparam int UID_W      = UID_BYTES * 8;
   localparam int LEN_W      = 4;
   localparam int PW_W       = 32;
   localparam int REQ_W      = 64;
   localparam int RSP_W      = 40;
   localparam int DIG_BYTES  = 20;
   localparam int WIN_WORDS  = 16;
   localparam int ROUNDS     = 80;

   localparam logic [LEN_W-1:0] UID_LEN  = LEN_W'(UID_BYTES);
   localparam logic [31:0]      MSG_BITS = 32'(UID_BYTES * 8);
   localparam logic [7:0]       PAD_BYTE = 8'h80;
   localparam logic [7:0]       XOR_A    = 8'hAA;
   localparam logic [7:0]       XOR_B    = 8'h55;

   localparam logic [31:0] SHA1_H [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   typedef logic [4:0] dig_idx_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   // x mod 20 for a byte: quotient by reciprocal 205/4096, exact below 256
   function automatic dig_idx_type mod20(input logic [7:0] x);
      logic [15:0] prod;
      logic [7:0]  rem;
      prod  = 16'(x) * 16'd205;
      rem   = x - 8'(prod[15:12] * 8'd20);
      mod20 = rem[4:0];
   endfunction

   // (a + inc) mod 20 for a < 20, inc < 20
   function automatic dig_idx_type add_mod20(input dig_idx_type a,
                                             input logic [4:0] inc);
      logic [5:0] s;
      s = 6'(a) + 6'(inc);
      if (s >= 6'(DIG_BYTES)) begin
         s = s - 6'(DIG_BYTES);
      end
      add_mod20 = s[4:0];
   endfunction

   // distance to the next picked digest byte: offsets 0, 5, 13, 17
   function automatic logic [4:0] sel_step(input logic [1:0] step);
      case (step)
         2'd0:    sel_step = 5'd5;
         2'd1:    sel_step = 5'd8;
         2'd2:    sel_step = 5'd4;
         default: sel_step = 5'd0;
      endcase
   endfunction

endpackage

// File: rtl/core/uid_password_derivation.sv
// ----------------------------------------------------------------------------
// uid_password_derivation: tag password from a 7-byte UID
// XOR mode mixes UID bytes; hash mode runs SHA-1 on one round unit and picks
// four digest bytes.
// ----------------------------------------------------------------------------
// Hash mode: 80 passes through the round unit, then the final add, the pick of
//   four digest bytes and the write-out. Either mode takes a new item only in idle.
// XOR mode or a length other than 7: the password is registered, then written out.
// A waiting result does not block the next item; it only holds the write-out.
// Reset (synchronous, active high) returns to idle, drops any pending result
//   and sets the mode to XOR.
`include "uid_password_derivation_defines.svh"

module uid_password_derivation (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,   // derive_mode
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [upd_pkg::REQ_W-1:0]   req_tdata,   // uid_bytes[55:0], uid_length[59:56]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [upd_pkg::RSP_W-1:0]   rsp_tdata    // password[31:0], generated[32]
);
   import upd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_FINAL = 3'd2;
   localparam logic [2:0] ST_MODK  = 3'd3;
   localparam logic [2:0] ST_SEL   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   // control
   logic [2:0]             state_ff, state_in;
   logic                   mode_ff, mode_in;
   logic [6:0]             rnd_ff, rnd_in;
   logic [1:0]             step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [31:0]            a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]            a_in, b_in, c_in, d_in, e_in;
   logic [31:0]            w_ff [WIN_WORDS];
   logic [31:0]            w_in [WIN_WORDS];
   logic [7:0]             dig_ff [DIG_BYTES];
   logic [7:0]             dig_in [DIG_BYTES];
   dig_idx_type            idx_ff, idx_in;
   logic [PW_W-1:0]        pw_ff, pw_in;
   logic                   gen_ff, gen_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                   req_take;
   logic [UID_W-1:0]       uid;
   logic [LEN_W-1:0]       uid_len;
   logic [31:0]            f_val, k_val, t_val, w_new;
   logic [31:0]            sum_w [5];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign uid        = req_tdata[UID_W-1:0];
   assign uid_len    = req_tdata[UID_W +: LEN_W];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Round unit: round function and constant by round group
   always_comb begin
      case (rnd_ff) inside
         [7'd0:7'd19]: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = K_R0;
         end
         [7'd20:7'd39]: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_R1;
         end
         [7'd40:7'd59]: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_R2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_R3;
         end
      endcase
   end

   assign t_val = rotl(a_ff, 5) + f_val + e_ff + k_val + w_ff[0];
   // next schedule word: w[i+16] from the 16-word window starting at w[i]
   assign w_new = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);

   // final chaining add
   assign sum_w[0] = SHA1_H[0] + a_ff;
   assign sum_w[1] = SHA1_H[1] + b_ff;
   assign sum_w[2] = SHA1_H[2] + c_ff;
   assign sum_w[3] = SHA1_H[3] + d_ff;
   assign sum_w[4] = SHA1_H[4] + e_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rnd_in       = rnd_ff;
      step_in      = step_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      w_in         = w_ff;
      dig_in       = dig_ff;
      idx_in       = idx_ff;
      pw_in        = pw_ff;
      gen_in       = gen_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         mode_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_WRITE;
               if (uid_len != UID_LEN) begin
                  // wrong length: no password in either mode
                  pw_in  = '0;
                  gen_in = 1'b0;
               end else if (!mode_ff) begin
                  pw_in  = {uid[47:40] ^ uid[31:24] ^ XOR_A,
                            uid[39:32] ^ uid[23:16] ^ XOR_B,
                            uid[31:24] ^ uid[15:8]  ^ XOR_A,
                            uid[23:16] ^ uid[7:0]   ^ XOR_B};
                  gen_in = 1'b1;
               end else begin
                  // load the single padded block and the initial chaining value
                  for (int i = 0; i < WIN_WORDS; i++) begin
                     w_in[i] = '0;
                  end
                  w_in[0]            = uid[55:24];
                  w_in[1]            = {uid[23:0], PAD_BYTE};
                  w_in[WIN_WORDS-1]  = MSG_BITS;
                  a_in     = SHA1_H[0];
                  b_in     = SHA1_H[1];
                  c_in     = SHA1_H[2];
                  d_in     = SHA1_H[3];
                  e_in     = SHA1_H[4];
                  rnd_in   = '0;
                  gen_in   = 1'b1;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            a_in = t_val;
            b_in = a_ff;
            c_in = rotl(b_ff, 30);
            d_in = c_ff;
            e_in = d_ff;
            for (int i = 0; i < WIN_WORDS - 1; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[WIN_WORDS-1] = w_new;
            if (rnd_ff == 7'(ROUNDS - 1)) begin
               state_in = ST_FINAL;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 4; j++) begin
                  dig_in[4*i+j] = sum_w[i][31-8*j -: 8];
               end
            end
            state_in = ST_MODK;
         end
         ST_MODK: begin
            idx_in   = mod20(dig_ff[0]);
            step_in  = '0;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            // shift in one picked byte per cycle, most significant first
            pw_in   = {pw_ff[PW_W-9:0], dig_ff[idx_ff]};
            idx_in  = add_mod20(idx_ff, sel_step(step_ff));
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_W - PW_W - 1)'(0), gen_ff, pw_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         rnd_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rnd_ff       <= rnd_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      w_ff        <= w_in;
      dig_ff      <= dig_in;
      idx_ff      <= idx_in;
      pw_ff       <= pw_in;
      gen_ff      <= gen_in;
      rsp_data_ff <= rsp_data_in;
   end

   `UPD_ASSERT(a_round_range, clock, reset, (state_ff == ST_ROUND) |-> (rnd_ff < 7'(ROUNDS)))
   `UPD_ASSERT(a_no_gen_zero, clock, reset, (rsp_tvalid && !rsp_tdata[PW_W]) |-> (rsp_tdata[PW_W-1:0] == '0))
   `UPD_ASSERT(a_accept_leaves_idle, clock, reset, req_take |=> (state_ff != ST_IDLE))
   `UPD_ASSERT(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WRITE))
   `UPD_ASSERT_NORST(a_reset_clears, clock, reset |=> (!rsp_tvalid && req_tready))

endmodule

// File: sim/upd_result_checker.sv
// ----------------------------------------------------------------------------
// upd_result_checker: scoreboard for the UID password derivation block
// Watches the mode register port and both streams, predicts each password
// on its own and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
package upd_test_pkg;

   typedef enum logic {
      MODE_XOR  = 1'b0,
      MODE_HASH = 1'b1
   } derive_mode_type;

   typedef struct packed {
      logic [upd_pkg::PW_W-1:0] password;
      logic                     generated;
   } pw_result_type;

endpackage

module upd_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [upd_pkg::REQ_W-1:0]   req_tdata,   // uid_bytes[55:0], uid_length[59:56]
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [upd_pkg::RSP_W-1:0]   rsp_tdata,   // password[31:0], generated[32]
   output int                          fail_count,
   output int                          pending_count,
   output int                          checked_count
);
   import upd_test_pkg::*;

   localparam logic [3:0] VALID_LEN    = 4'd7;
   localparam logic [7:0] MIX_HI       = 8'hAA;
   localparam logic [7:0] MIX_LO       = 8'h55;
   localparam int         DIGEST_BYTES = 20;

   derive_mode_type mode = MODE_XOR;
   pw_result_type   expected_pw [$];
   int              mismatches;
   int              checked;

   // SHA-1 of the seven UID bytes, padded into a single 512-bit block
   function automatic logic [159:0] sha1_of_uid(input logic [55:0] uid);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, kc, t, x;
      int          i;
      w[0] = uid[55:24];
      w[1] = {uid[23:0], 8'h80};
      for (i = 2; i < 15; i++) begin
         w[i] = 32'h0;
      end
      w[15] = 32'd56;
      for (i = 16; i < 80; i++) begin
         x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {x[30:0], x[31]};
      end
      a = 32'h67452301;
      b = 32'hEFCDAB89;
      c = 32'h98BADCFE;
      d = 32'h10325476;
      e = 32'hC3D2E1F0;
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f  = (b & c) | (~b & d);
            kc = 32'h5A827999;
         end else if (i < 40) begin
            f  = b ^ c ^ d;
            kc = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f  = (b & c) | (b & d) | (c & d);
            kc = 32'h8F1BBCDC;
         end else begin
            f  = b ^ c ^ d;
            kc = 32'hCA62C1D6;
         end
         t = {a[26:0], a[31:27]} + f + e + kc + w[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      return {a + 32'h67452301, b + 32'hEFCDAB89, c + 32'h98BADCFE,
              d + 32'h10325476, e + 32'hC3D2E1F0};
   endfunction

   function automatic pw_result_type derive_password(input logic [55:0]    uid,
                                                     input logic [3:0]     len,
                                                     input derive_mode_type how);
      pw_result_type  res;
      logic [7:0]     ub [7];
      logic [7:0]     db [DIGEST_BYTES];
      logic [159:0]   dig;
      int             i;
      int             s;
      res = '0;
      if (len != VALID_LEN) begin
         return res;
      end
      for (i = 0; i < 7; i++) begin
         ub[i] = uid[55-8*i -: 8];
      end
      if (how == MODE_XOR) begin
         res.password = {ub[1] ^ ub[3] ^ MIX_HI, ub[2] ^ ub[4] ^ MIX_LO,
                         ub[3] ^ ub[5] ^ MIX_HI, ub[4] ^ ub[6] ^ MIX_LO};
      end else begin
         dig = sha1_of_uid(uid);
         for (i = 0; i < DIGEST_BYTES; i++) begin
            db[i] = dig[159-8*i -: 8];
         end
         s = db[0] % DIGEST_BYTES;
         res.password = {db[s], db[(s + 5) % DIGEST_BYTES],
                         db[(s + 13) % DIGEST_BYTES], db[(s + 17) % DIGEST_BYTES]};
      end
      res.generated = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      pw_result_type got;
      pw_result_type want;
      if (reset) begin
         mode = MODE_XOR;
         expected_pw.delete();
      end else begin
         if (csr_we) begin
            mode = derive_mode_type'(csr_wdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.password  = rsp_tdata[31:0];
            got.generated = rsp_tdata[32];
            checked++;
            if (expected_pw.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected result password %h generated %b",
                           $time, got.password, got.generated);
               end
            end else begin
               want = expected_pw.pop_front();
               if (got.password !== want.password || got.generated !== want.generated) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result %0d expected password %h generated %b, got %h %b",
                              $time, checked, want.password, want.generated,
                              got.password, got.generated);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_pw.push_back(derive_password(req_tdata[55:0], req_tdata[59:56], mode));
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_pw.size();
      checked_count <= checked;
   end

endmodule

// File: sim/uid_password_derivation_test.sv
// ----------------------------------------------------------------------------
// uid_password_derivation_test: stimulus and verdict for password derivation
// Runs edge-case UIDs in both derivation modes, then random phases that
// set the mode before each phase, with random gaps on both streams and one
// long result hold-off. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module uid_password_derivation_test;
   import upd_test_pkg::*;

   // no acceptance on either stream for this many cycles ends the run
   localparam int IDLE_LIMIT   = 5000;
   localparam int PHASE_ITEMS  = 250;
   // hold-off of the result stream once this many results got through
   localparam int SQUEEZE_AT   = 200;
   localparam int SQUEEZE_LEN  = 400;
   // cycles to settle at the end, longer than a hash-mode item takes
   localparam int SETTLE_CYCLES = 100;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        csr_we     = 1'b0;
   logic                        csr_wdata  = 1'b0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [upd_pkg::REQ_W-1:0]   req_tdata  = '0;   // uid_bytes[55:0], uid_length[59:56]
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [upd_pkg::RSP_W-1:0]   rsp_tdata;         // password[31:0], generated[32]

   int fail_count;
   int pending_count;
   int checked_count;

   derive_mode_type current_mode = MODE_XOR;
   derive_mode_type phase_modes [6] = '{MODE_XOR, MODE_HASH, MODE_XOR,
                                        MODE_HASH, MODE_HASH, MODE_XOR};
   int xor_items;
   int hash_items;
   int short_items;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   uid_password_derivation uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   upd_result_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Offer one UID item after a random gap and hold it until accepted.
   // With no gap, tvalid stays high straight into the next item.
   task automatic offer_uid(input logic [55:0] uid, input logic [3:0] len);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         gap = 0;
      end else if (r < 88) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 20);
      end else begin
         gap = $urandom_range(30, 90);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {4'b0000, len, uid};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (len != 4'd7) begin
         short_items++;
      end else if (current_mode == MODE_HASH) begin
         hash_items++;
      end else begin
         xor_items++;
      end
   endtask

   // Drop tvalid and wait until every predicted result has come back.
   // The checker's count is registered, so wait for a clock edge before looking.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Write the mode register; only called while the block is idle.
   task automatic set_mode(input derive_mode_type m);
      csr_wdata <= m;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      current_mode = m;
   endtask

   // Field extremes, single set bits, a UID that differs only in the first byte
   // (unused in XOR mode), and lengths from 0 and around 7 up to the largest 4-bit value.
   task automatic offer_edge_cases();
      offer_uid(56'h0, 4'd7);
      offer_uid({56{1'b1}}, 4'd7);
      offer_uid(56'h0123456789ABCD, 4'd7);
      offer_uid(56'hFE23456789ABCD, 4'd7);
      offer_uid(56'h80000000000000, 4'd7);
      offer_uid(56'h00000000000001, 4'd7);
      offer_uid({56{1'b1}}, 4'd0);
      offer_uid({56{1'b1}}, 4'd6);
      offer_uid({56{1'b1}}, 4'd8);
      offer_uid({56{1'b1}}, 4'd15);
      drain_results();
   endtask

   initial begin : stimulus
      logic [63:0] raw;
      int          r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // XOR mode straight out of reset, then hash mode
      offer_edge_cases();
      set_mode(MODE_HASH);
      offer_edge_cases();

      // random phases; mostly valid lengths so the derivation paths get most items
      foreach (phase_modes[p]) begin
         set_mode(phase_modes[p]);
         repeat (PHASE_ITEMS) begin
            raw = {$urandom, $urandom};
            r   = $urandom_range(0, 99);
            offer_uid(raw[55:0], (r < 80) ? 4'd7 : 4'($urandom_range(0, 15)));
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Derived %0d XOR-mode and %0d hash-mode passwords, sent %0d wrong-length UIDs,",
               xor_items, hash_items, short_items);
      $display("across %0d mode phases; %0d results compared, %0d mismatches.",
               $size(phase_modes) + 2, checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Result-side backpressure: open stretches alternate with stalls that are
   // mostly short and now and then long. Once, after a number of results,
   // hold off for a long stretch so the block fills up and stalls its input.
   int open_left;
   int stall_left;
   int delivered;
   bit squeezed;

   always @(posedge clock) begin : receiver
      int r;
      if (rsp_tvalid && rsp_tready) begin
         delivered++;
      end
      if (!squeezed && delivered >= SQUEEZE_AT) begin
         squeezed   = 1'b1;
         open_left  = 0;
         stall_left = SQUEEZE_LEN;
      end
      if (open_left == 0 && stall_left == 0) begin
         open_left = $urandom_range(1, 40);
         r = $urandom_range(0, 99);
         if (r < 55) begin
            stall_left = 0;
         end else if (r < 88) begin
            stall_left = $urandom_range(1, 4);
         end else if (r < 97) begin
            stall_left = $urandom_range(5, 20);
         end else begin
            stall_left = $urandom_range(30, 80);
         end
      end
      if (open_left > 0) begin
         open_left--;
         rsp_tready <= 1'b1;
      end else begin
         stall_left--;
         rsp_tready <= 1'b0;
      end
   end

   // Watchdog: count cycles with no item moving on either stream.
   int idle_cycles;

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
